// ----- hw/rtl/scd_pkg.sv -----
`default_nettype none
package scd_pkg;

    localparam int DEF_FRAME_STORE_PIXELS = 2097152;
    localparam int DEF_HISTORY_DEPTH      = 5;

    localparam int CFG_W     = 16;
    localparam int DIM_W     = 13;
    localparam int LUMA_W    = 8;
    localparam int SCORE_W   = 16;
    localparam int THR_W     = 17;
    localparam int T10_W     = 21;
    localparam int PROD_W    = 2 * DIM_W;

    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd1920;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd1080;
    localparam logic [SCORE_W-1:0] RST_SCORE_FLOOR  = 16'd1280;
    localparam logic [SCORE_W-1:0] RST_STRONG_SCORE = 16'd12800;

    // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every x below 2^22
    localparam int RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;
    localparam int RECIP_SHIFT = 23;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SCORE_FLOOR  = 2'd2,
        REG_STRONG_SCORE = 2'd3
    } scd_reg_t;

    typedef struct packed {
        logic                 valid;
        logic [SCORE_W-1:0]   score;
    } scd_score_t;

endpackage
`default_nettype wire

// ----- hw/rtl/video_scene_change_detector_top.sv -----
// Pixel path: one luma transaction per cycle while in_ready is high, frame store read and written in the same cycle.
// Frame end: the score is worked out in the bit-serial divider, then goes through the history
// scan and the threshold before the result shows.
// While one frame's score is still in flight, a pixel that could close the next frame waits.
// Reset clears counters, history and registers; the frame store is not cleared and holds
// nothing usable until the first frame after reset has been written.
`default_nettype none
module video_scene_change_detector_top #(
    parameter int FRAME_STORE_PIXELS = scd_pkg::DEF_FRAME_STORE_PIXELS,
    parameter int HISTORY_DEPTH      = scd_pkg::DEF_HISTORY_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [scd_pkg::LUMA_W-1:0]    luma,
    input  wire logic                          frame_start,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [scd_pkg::SCORE_W-1:0]   mean_difference,
    output logic      [scd_pkg::THR_W-1:0]     adaptive_threshold,
    output logic                               scene_change,
    output logic      [scd_pkg::SCORE_W-1:0]   change_number,
    input  wire logic                          cfg_write,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [scd_pkg::CFG_W-1:0]     cfg_data
);
    import scd_pkg::*;

    localparam int AW = $clog2(FRAME_STORE_PIXELS);
    localparam int CW = $clog2(FRAME_STORE_PIXELS + 1);
    localparam int SW = AW + LUMA_W;
    localparam int PW = (PROD_W > CW) ? PROD_W : CW;
    localparam int DEF_PIX_RAW = 1920 * 1080;
    localparam int DEF_PIX = (DEF_PIX_RAW > FRAME_STORE_PIXELS) ? FRAME_STORE_PIXELS
                                                                : DEF_PIX_RAW;

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [SCORE_W-1:0] floor_reg;
    logic [SCORE_W-1:0] strong_reg;
    logic [CW-1:0]      npix_reg, npix_next;

    logic [CW-1:0]      pix_cnt_reg, pix_cnt_next;
    logic               have_prev_reg;
    logic [SW-1:0]      sum_reg;

    logic               s1_valid_reg;
    logic [LUMA_W-1:0]  s1_luma_reg;
    logic               s1_use_reg;
    logic               s1_first_reg;
    logic               s1_last_reg;

    logic [DIM_W-1:0]   w_nx, h_nx;
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [PW-1:0]      dim_prod;
    logic               accept;
    logic               restart;
    logic [CW-1:0]      cur_addr;
    logic [CW:0]        cnt_inc;
    logic               frame_end;
    logic               may_end;
    logic               post_busy;
    logic               clear_hist;
    logic [LUMA_W-1:0]  prev_luma;
    logic [LUMA_W-1:0]  abs_diff;
    logic [SW-1:0]      sum_total;
    logic               div_start;
    logic               div_busy;
    logic               dec_take;
    logic               dec_busy;
    scd_score_t         div_result;

    // frame size follows the values being written, so it is current right after a write
    assign w_nx     = (cfg_write && (cfg_index == REG_FRAME_WIDTH)) ? cfg_data[DIM_W-1:0]
                                                                    : width_reg;
    assign h_nx     = (cfg_write && (cfg_index == REG_FRAME_HEIGHT)) ? cfg_data[DIM_W-1:0]
                                                                     : height_reg;
    assign w_eff    = (w_nx == '0) ? DIM_W'(1) : w_nx;
    assign h_eff    = (h_nx == '0) ? DIM_W'(1) : h_nx;
    assign dim_prod = PW'(w_eff) * PW'(h_eff);
    assign npix_next = (dim_prod > PW'(FRAME_STORE_PIXELS)) ? CW'(FRAME_STORE_PIXELS)
                                                            : CW'(dim_prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            floor_reg  <= RST_SCORE_FLOOR;
            strong_reg <= RST_STRONG_SCORE;
            npix_reg   <= CW'(DEF_PIX);
        end
        else
        begin
            npix_reg <= npix_next;
            if (cfg_write)
            begin
                unique case (scd_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    REG_SCORE_FLOOR:  floor_reg  <= cfg_data[SCORE_W-1:0];
                    REG_STRONG_SCORE: strong_reg <= cfg_data[SCORE_W-1:0];
                endcase
            end
        end
    end

    assign restart   = frame_start || (pix_cnt_reg >= npix_reg);
    assign cur_addr  = restart ? '0 : pix_cnt_reg;
    assign cnt_inc   = {1'b0, cur_addr} + 1'b1;
    assign frame_end = cnt_inc >= {1'b0, npix_reg};

    assign post_busy = (s1_valid_reg && s1_last_reg) || div_busy || dec_busy;
    // a frame-closing pixel waits until the previous score has left the pipeline
    assign may_end   = (({1'b0, pix_cnt_reg} + 1'b1) >= {1'b0, npix_reg})
                       || (npix_reg == CW'(1));
    assign in_ready  = !(post_busy && may_end);
    assign accept    = in_valid && in_ready;
    assign pix_cnt_next = frame_end ? '0 : cnt_inc[CW-1:0];
    assign clear_hist   = accept && frame_end && !have_prev_reg;

    scd_ram #(
        .WIDTH(LUMA_W),
        .DEPTH(FRAME_STORE_PIXELS)
    ) u_store (
        .clk  (clk),
        .we   (accept),
        .addr (cur_addr[AW-1:0]),
        .wdata(luma),
        .rdata(prev_luma)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg   <= '0;
            have_prev_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                pix_cnt_reg  <= pix_cnt_next;
                s1_luma_reg  <= luma;
                s1_use_reg   <= have_prev_reg;
                s1_first_reg <= (cur_addr == '0);
                s1_last_reg  <= frame_end && have_prev_reg;
                if (frame_end)
                begin
                    have_prev_reg <= 1'b1;
                end
            end
            if (s1_valid_reg)
            begin
                sum_reg <= s1_last_reg ? '0 : sum_total;
            end
        end
    end

    assign abs_diff  = (s1_luma_reg >= prev_luma) ? (s1_luma_reg - prev_luma)
                                                  : (prev_luma - s1_luma_reg);
    assign sum_total = (s1_first_reg ? '0 : sum_reg) + (s1_use_reg ? SW'(abs_diff) : '0);
    assign div_start = s1_valid_reg && s1_last_reg;

    scd_div #(
        .NW(SW),
        .DW(CW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(sum_total),
        .divisor (npix_reg),
        .take    (dec_take),
        .result  (div_result),
        .busy    (div_busy)
    );

    scd_decide #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_decide (
        .clk               (clk),
        .rst_n             (rst_n),
        .clear_hist        (clear_hist),
        .score_in          (div_result),
        .take              (dec_take),
        .busy              (dec_busy),
        .score_floor       (floor_reg),
        .strong_score      (strong_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .mean_difference   (mean_difference),
        .adaptive_threshold(adaptive_threshold),
        .scene_change      (scene_change),
        .change_number     (change_number)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/scd_ram.sv -----
`default_nettype none
module scd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a write and a read of one address give the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/scd_div.sv -----
`default_nettype none
module scd_div #(
    parameter int NW = 29,
    parameter int DW = 22
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    input  wire logic          take,
    output scd_pkg::scd_score_t result,
    output logic               busy
);
    import scd_pkg::*;

    // quotient of (dividend * 256) / divisor, one bit per cycle
    localparam int STEPS = NW + LUMA_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STEPS-1:0]    dvd_reg, dvd_next;
    logic [DW-1:0]       den_reg, den_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [SCORE_W-1:0]  quot_reg, quot_next;
    logic [DW:0]         rem_sh;
    logic [DW:0]         rem_sub;
    logic                ge;

    assign rem_sh  = {rem_reg, dvd_reg[STEPS-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            dvd_next  = {dividend, {LUMA_W{1'b0}}};
            den_next  = divisor;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (run_reg)
        begin
            dvd_next  = {dvd_reg[STEPS-2:0], 1'b0};
            rem_next  = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            // true quotient fits in the score width, upper bits are zero
            quot_next = {quot_reg[SCORE_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && take)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign result.valid = done_reg;
    assign result.score = quot_reg;
    assign busy         = run_reg | done_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/scd_decide.sv -----
`default_nettype none
module scd_decide #(
    parameter int HISTORY_DEPTH = 5
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clear_hist,
    input  wire scd_pkg::scd_score_t          score_in,
    output logic                              take,
    output logic                              busy,
    input  wire logic [scd_pkg::SCORE_W-1:0]  score_floor,
    input  wire logic [scd_pkg::SCORE_W-1:0]  strong_score,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [scd_pkg::SCORE_W-1:0]  mean_difference,
    output logic      [scd_pkg::THR_W-1:0]    adaptive_threshold,
    output logic                              scene_change,
    output logic      [scd_pkg::SCORE_W-1:0]  change_number
);
    import scd_pkg::*;

    localparam int IW  = $clog2(HISTORY_DEPTH);
    localparam int MW  = T10_W + RECIP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_MULT,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [SCORE_W-1:0]  hist_reg [HISTORY_DEPTH];
    logic [1:0]          fc_reg;
    logic [IW-1:0]       idx_reg;
    logic [SCORE_W-1:0]  score_reg;
    logic [SCORE_W-1:0]  mx_reg;
    logic [SCORE_W-1:0]  mn_reg;
    logic [T10_W-1:0]    t10_reg;
    logic                flag_reg;
    logic [MW-1:0]       prod_reg;
    logic [SCORE_W-1:0]  cnt_reg;
    logic                out_valid_reg;
    logic [SCORE_W-1:0]  mean_reg;
    logic [THR_W-1:0]    thr_reg;
    logic                change_reg;
    logic [SCORE_W-1:0]  num_reg;

    logic [SCORE_W-1:0]  hval;
    logic [T10_W-1:0]    t10_calc;
    logic [T10_W-1:0]    s10;
    logic [T10_W-1:0]    s4;
    logic                flag_calc;

    assign hval     = hist_reg[idx_reg];
    assign t10_calc = (T10_W'(mx_reg) << 4) + (T10_W'(mx_reg) << 1) - (T10_W'(mn_reg) << 3);
    assign s10      = (T10_W'(score_reg) << 3) + (T10_W'(score_reg) << 1);
    assign s4       = T10_W'(score_reg) << 2;
    // history warm-up count, floor rule, then ratio window, then strong score
    assign flag_calc = (fc_reg == 2'd3) && (score_reg >= score_floor) && !(s10 < t10_calc)
                       && ((s4 > t10_calc) || (score_reg > strong_score));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fc_reg        <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (clear_hist)
                    begin
                        fc_reg <= '0;
                        for (int i = 0; i < HISTORY_DEPTH; i++)
                        begin
                            hist_reg[i] <= '0;
                        end
                    end
                    else if (score_in.valid)
                    begin
                        for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                        begin
                            hist_reg[i] <= hist_reg[i+1];
                        end
                        hist_reg[HISTORY_DEPTH-1] <= score_in.score;
                        score_reg <= score_in.score;
                        if (fc_reg != 2'd3)
                        begin
                            fc_reg <= fc_reg + 2'd1;
                        end
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg == '0)
                    begin
                        mx_reg <= hval;
                        mn_reg <= hval;
                    end
                    else
                    begin
                        if (hval > mx_reg)
                        begin
                            mx_reg <= hval;
                        end
                        if (hval < mn_reg)
                        begin
                            mn_reg <= hval;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IW'(HISTORY_DEPTH - 2))
                    begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    t10_reg   <= t10_calc;
                    flag_reg  <= flag_calc;
                    state_reg <= ST_MULT;
                end
                ST_MULT:
                begin
                    prod_reg  <= MW'(t10_reg) * MW'(RECIP_TEN);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        mean_reg      <= score_reg;
                        thr_reg       <= prod_reg[RECIP_SHIFT +: THR_W];
                        change_reg    <= flag_reg;
                        num_reg       <= cnt_reg;
                        if (flag_reg)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign take               = (state_reg == ST_IDLE) && !clear_hist;
    assign busy               = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid          = out_valid_reg;
    assign mean_difference    = mean_reg;
    assign adaptive_threshold = thr_reg;
    assign scene_change       = change_reg;
    assign change_number      = num_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/scd_checker.sv -----
`default_nettype none
module scd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] mean_difference,
    input wire logic [16:0] adaptive_threshold,
    input wire logic        scene_change,
    input wire logic [15:0] change_number
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean_difference)
        && $stable(change_number))
        else $error("result changed while stalled");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mean_difference <= 16'd65280)
        else $error("mean difference out of range");

    a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> adaptive_threshold <= 17'd117504)
        else $error("threshold out of range");

    // a zero score can never pass the ratio or strong rule
    a_change_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scene_change |-> mean_difference != 16'd0)
        else $error("change flagged on zero score");

endmodule

bind video_scene_change_detector_top scd_checker u_scd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .mean_difference   (mean_difference),
    .adaptive_threshold(adaptive_threshold),
    .scene_change      (scene_change),
    .change_number     (change_number)
);
`default_nettype wire
